### rtl/core/owi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry integrator package
// Shared widths, codes, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package owi_pkg;

	localparam int AW    = 56;            // multiplicand width (signed)
	localparam int BW    = 34;            // multiplier width, serial (signed)
	localparam int PW    = AW + 1 + BW;   // product width
	localparam int CW    = 34;            // CORDIC datapath width
	localparam int IN_W  = 48;
	localparam int OUT_W = 192;

	localparam logic [30:0] PI_Q28      = 31'd843314857;
	localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
	localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_K_Q30 = 34'sd652032874;
	// offset of 2^25 turns; keeps any heading sum positive for the reduction
	localparam logic [57:0] MOD_OFFSET = 58'd1686629713 << 25;
	localparam int MOD_BITS = 58;

	typedef enum logic [2:0] {
		REG_MPC, REG_ITW, REG_LATG, REG_FWDG, REG_TURNG, REG_RATE
	} reg_t;

	typedef enum logic [3:0] {
		OP_MS, OP_ML, OP_MR, OP_LAT, OP_FWD, OP_TQ, OP_DTH,
		OP_LC, OP_FS, OP_LS, OP_FC, OP_VX, OP_VY, OP_TR
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_START, ST_MUL, ST_MOD, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		QD_NONE, QD_POS, QD_NEG
	} quad_t;

	typedef struct packed {
		logic                 start;
		logic signed [AW-1:0] a;
		logic        [BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [PW-1:0] prod;
	} mul_rsp_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] k);
		logic [29:0] v;
		case (k)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/core/owi_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed AW x signed BW product, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module owi_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  owi_pkg::mul_req_t req,
	output owi_pkg::mul_rsp_t rsp
);
	import owi_pkg::*;

	localparam logic [5:0] CNT_LAST = 6'(BW - 1);

	logic signed [AW-1:0] a_q;
	logic        [BW-1:0] b_q;
	logic signed [AW:0]   hi_q;
	logic        [BW-1:0] lo_q;
	logic        [5:0]    cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic                 last;
	logic signed [AW+1:0] a_ext;
	logic signed [AW+1:0] addend;
	logic signed [AW+1:0] sum;

	always_comb begin
		last  = (cnt_q == CNT_LAST);
		a_ext = (AW+2)'(a_q);
		// top multiplier bit carries negative weight
		if (b_q[0]) begin
			addend = last ? -a_ext : a_ext;
		end else begin
			addend = '0;
		end
		sum = (AW+2)'(hi_q) + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (run_q) begin
			b_q  <= b_q >> 1;
			hi_q <= sum[AW+1:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {hi_q, lo_q};

endmodule
`default_nettype wire

### rtl/core/three_wheel_odometry_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// The first request after reset only primes the counts and gives no result.
// Later requests: 14 products on the bit-serial multiplier, then a bit-serial heading
// reduction modulo two pi; one request at a time.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low): registers to defaults, pose and stored counts to zero, unprimed.
// ----------------------------------------------------------------------------
// Three-wheel odometry integrator
// Encoder deltas to body motion, CORDIC rotation to world frame, pose integration.
// ----------------------------------------------------------------------------
module three_wheel_odometry_integrator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// side_count [15:0], left_count [31:16], right_count [47:32]
	input  logic [owi_pkg::IN_W-1:0]    s_axis_tdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pos_x [31:0], pos_y [63:32], heading [94:64], vel_x [126:95],
	// vel_y [158:127], turn_rate [190:159], zero [191]
	output logic [owi_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import owi_pkg::*;

	localparam int CKW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CKW-1:0] CK_LAST = CKW'(CORDIC_STEPS - 1);
	localparam logic [5:0] MCNT_LAST = 6'(MOD_BITS - 1);

	state_t state_q, state_d;
	op_t    op_q;
	logic   primed_q;

	logic [31:0] mpc_q, itw_q;
	logic [15:0] latg_q, fwdg_q, turng_q;
	logic [9:0]  rate_q;

	logic [15:0] last_side_q, last_left_q, last_right_q;
	logic signed [15:0] ds_q, dl_q, dr_q;
	logic signed [39:0] ms_q, ml_q, mr_q;
	logic signed [33:0] lat_q, fwd_q;
	logic signed [42:0] tq_q;
	logic signed [54:0] dth_q;
	logic [63:0] lc_q, ls_q;
	logic [31:0] dxw_q, dyw_q, velx_q, vely_q, trate_q;
	logic [31:0] world_x_q, world_y_q;
	logic signed [31:0] yaw_q;

	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [CKW-1:0] ck_q;
	logic           crun_q;
	quad_t          quad_q;

	logic [MOD_BITS-1:0] vp_q;
	logic [30:0]         rem_q;
	logic [5:0]          mcnt_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic        in_acc, cfg_we, wb, out_load;
	logic [15:0] s_in, l_in, r_in;
	logic signed [40:0] fsum, fdiff;
	logic [PW-1:0] rnd, psum;
	logic [63:0] dx_full, dy_full;
	logic signed [CW-1:0] cos_v, sin_v, z4, xs, ys, at_v;
	logic signed [55:0] hsum;
	logic [31:0] mod_t;
	logic signed [31:0] h_v;
	logic [31:0] wx_new, wy_new;

	owi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign pready        = 1'b1;
	assign cfg_we        = psel && penable && pwrite;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign s_in = s_axis_tdata[15:0];
	assign l_in = s_axis_tdata[31:16];
	assign r_in = 16'd0 - s_axis_tdata[47:32];

	always_comb begin
		case (reg_t'(paddr[4:2]))
			REG_MPC:   prdata = mpc_q;
			REG_ITW:   prdata = itw_q;
			REG_LATG:  prdata = 32'(latg_q);
			REG_FWDG:  prdata = 32'(fwdg_q);
			REG_TURNG: prdata = 32'(turng_q);
			REG_RATE:  prdata = 32'(rate_q);
			default:   prdata = '0;
		endcase
	end

	// rotation by quadrant fold
	always_comb begin
		if (quad_q == QD_POS) begin
			cos_v = -cy_q;
			sin_v = cx_q;
		end else if (quad_q == QD_NEG) begin
			cos_v = cy_q;
			sin_v = -cx_q;
		end else begin
			cos_v = cx_q;
			sin_v = cy_q;
		end
		z4   = {yaw_q, 2'b00};
		xs   = cx_q >>> ck_q;
		ys   = cy_q >>> ck_q;
		at_v = $signed({4'b0000, atan_q30(5'(ck_q))});
	end

	// operand select for the current product
	always_comb begin
		fsum        = 41'(ml_q) + 41'(mr_q);
		fdiff       = 41'(mr_q) - 41'(ml_q);
		mul_req.start = (state_q == ST_START);
		mul_req.a   = '0;
		mul_req.b   = '0;
		rnd         = '0;
		case (op_q)
			OP_MS: begin
				mul_req.a = AW'(ds_q);  mul_req.b = BW'(mpc_q);   rnd = PW'(1) << 7;
			end
			OP_ML: begin
				mul_req.a = AW'(dl_q);  mul_req.b = BW'(mpc_q);   rnd = PW'(1) << 7;
			end
			OP_MR: begin
				mul_req.a = AW'(dr_q);  mul_req.b = BW'(mpc_q);   rnd = PW'(1) << 7;
			end
			OP_LAT: begin
				mul_req.a = AW'(ms_q);  mul_req.b = BW'(latg_q);  rnd = PW'(1) << 21;
			end
			OP_FWD: begin
				mul_req.a = AW'(fsum);  mul_req.b = BW'(fwdg_q);  rnd = PW'(1) << 22;
			end
			OP_TQ: begin
				mul_req.a = AW'(fdiff); mul_req.b = BW'(turng_q); rnd = PW'(1) << 13;
			end
			OP_DTH: begin
				mul_req.a = AW'(tq_q);  mul_req.b = BW'(itw_q);   rnd = PW'(1) << 19;
			end
			OP_LC: begin
				mul_req.a = AW'(lat_q); mul_req.b = cos_v;
			end
			OP_FS: begin
				mul_req.a = AW'(fwd_q); mul_req.b = sin_v;
			end
			OP_LS: begin
				mul_req.a = AW'(lat_q); mul_req.b = sin_v;
			end
			OP_FC: begin
				mul_req.a = AW'(fwd_q); mul_req.b = cos_v;
			end
			OP_VX: begin
				mul_req.a = AW'(dxw_q); mul_req.b = BW'(rate_q);
			end
			OP_VY: begin
				mul_req.a = AW'(dyw_q); mul_req.b = BW'(rate_q);
			end
			OP_TR: begin
				mul_req.a = AW'(dth_q); mul_req.b = BW'(rate_q);  rnd = PW'(1) << 11;
			end
			default: ;
		endcase
		psum    = mul_rsp.prod + rnd;
		dx_full = lc_q - mul_rsp.prod[63:0] + 64'd536870912;
		dy_full = ls_q + mul_rsp.prod[63:0] + 64'd536870912;
	end

	always_comb begin
		hsum  = 56'(yaw_q) + 56'(dth_q);
		mod_t = {rem_q, vp_q[MOD_BITS-1]};
		if (mod_t >= 32'(TWO_PI_Q28)) begin
			mod_t = mod_t - 32'(TWO_PI_Q28);
		end
		if (rem_q > PI_Q28) begin
			h_v = $signed(32'(rem_q)) - $signed(32'(TWO_PI_Q28));
		end else begin
			h_v = $signed(32'(rem_q));
		end
		wx_new = world_x_q + dxw_q;
		wy_new = world_y_q + dyw_q;
	end

	always_comb begin
		state_d  = state_q;
		wb       = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && primed_q) begin
					state_d = ST_START;
				end
			end
			ST_START: state_d = ST_MUL;
			ST_MUL: begin
				if (mul_rsp.done) begin
					wb      = 1'b1;
					state_d = (op_q == OP_TR) ? ST_MOD : ST_START;
				end
			end
			ST_MOD: begin
				if (mcnt_q == MCNT_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q        <= 32'd658831;
			itw_q        <= 32'd43577184;
			latg_q       <= 16'd16384;
			fwdg_q       <= 16'd16384;
			turng_q      <= 16'd16384;
			rate_q       <= 10'd50;
			op_q         <= OP_MS;
			primed_q     <= 1'b0;
			last_side_q  <= '0;
			last_left_q  <= '0;
			last_right_q <= '0;
			world_x_q    <= '0;
			world_y_q    <= '0;
			yaw_q        <= '0;
			crun_q       <= 1'b0;
			ck_q         <= '0;
			quad_q       <= QD_NONE;
			mcnt_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_t'(paddr[4:2]))
					REG_MPC:   mpc_q   <= pwdata;
					REG_ITW:   itw_q   <= pwdata;
					REG_LATG:  latg_q  <= pwdata[15:0];
					REG_FWDG:  fwdg_q  <= pwdata[15:0];
					REG_TURNG: turng_q <= pwdata[15:0];
					REG_RATE:  rate_q  <= pwdata[9:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				primed_q     <= 1'b1;
				last_side_q  <= s_in;
				last_left_q  <= l_in;
				last_right_q <= r_in;
				op_q         <= OP_MS;
			end
			// CORDIC runs alongside the first products
			if (in_acc && primed_q) begin
				crun_q <= 1'b1;
				ck_q   <= '0;
				if (z4 > HALF_PI_Q30) begin
					quad_q <= QD_POS;
				end else if (z4 < -HALF_PI_Q30) begin
					quad_q <= QD_NEG;
				end else begin
					quad_q <= QD_NONE;
				end
			end else if (crun_q) begin
				ck_q <= ck_q + CKW'(1);
				if (ck_q == CK_LAST) begin
					crun_q <= 1'b0;
				end
			end
			if (wb && op_q != OP_TR) begin
				op_q <= op_t'(op_q + 4'd1);
			end
			if (wb && op_q == OP_TR) begin
				mcnt_q <= '0;
			end else if (state_q == ST_MOD) begin
				mcnt_q <= mcnt_q + 6'd1;
			end
			if (out_load) begin
				world_x_q <= wx_new;
				world_y_q <= wy_new;
				yaw_q     <= h_v;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ds_q <= $signed(s_in - last_side_q);
			dl_q <= $signed(l_in - last_left_q);
			dr_q <= $signed(r_in - last_right_q);
		end
		if (in_acc && primed_q) begin
			cy_q <= '0;
			cx_q <= CORDIC_K_Q30;
			if (z4 > HALF_PI_Q30) begin
				cz_q <= z4 - HALF_PI_Q30;
			end else if (z4 < -HALF_PI_Q30) begin
				cz_q <= z4 + HALF_PI_Q30;
			end else begin
				cz_q <= z4;
			end
		end else if (crun_q) begin
			if (!cz_q[CW-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at_v;
			end
		end
		if (wb) begin
			case (op_q)
				OP_MS:  ms_q    <= psum[47:8];
				OP_ML:  ml_q    <= psum[47:8];
				OP_MR:  mr_q    <= psum[47:8];
				OP_LAT: lat_q   <= psum[55:22];
				OP_FWD: fwd_q   <= psum[56:23];
				OP_TQ:  tq_q    <= psum[56:14];
				OP_DTH: dth_q   <= psum[74:20];
				OP_LC:  lc_q    <= psum[63:0];
				OP_FS:  dxw_q   <= dx_full[61:30];
				OP_LS:  ls_q    <= psum[63:0];
				OP_FC:  dyw_q   <= dy_full[61:30];
				OP_VX:  velx_q  <= psum[31:0];
				OP_VY:  vely_q  <= psum[31:0];
				OP_TR: begin
					trate_q <= psum[43:12];
					vp_q    <= 58'(hsum) + MOD_OFFSET;
					rem_q   <= '0;
				end
				default: ;
			endcase
		end else if (state_q == ST_MOD) begin
			// restoring reduction modulo two pi, one bit per cycle
			rem_q <= mod_t[30:0];
			vp_q  <= vp_q << 1;
		end
		if (out_load) begin
			out_data_q <= {1'b0, trate_q, vely_q, velx_q, h_v[30:0], wy_new, wx_new};
		end
	end

endmodule
`default_nettype wire

### rtl/core/owi_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry integrator port checker
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module owi_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic [191:0] m_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_heading: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[94:64]) >= -32'sd843314856) &&
			($signed(m_axis_tdata[94:64]) <= 32'sd843314857))
		else $error("heading outside minus pi to pi");

	a_busy_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without processing");

endmodule

bind three_wheel_odometry_integrator owi_chk u_owi_chk (.*);
`default_nettype wire

### tb/odo_pose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry pose checker
// Watches the register port and both streams, predicts each pose and compares.
// ----------------------------------------------------------------------------
module odo_pose_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [47:0]  s_axis_tdata,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [191:0] m_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatches,
	output int           pending,
	output int           poses_checked
);
	import owi_pkg::*;

	localparam longint PI_Q28_L     = 64'sd843314857;
	localparam longint TWO_PI_Q28_L = 64'sd1686629713;
	localparam longint HALF_PI_Q30_L = 64'sd1686629713;
	localparam longint GAIN_K_Q30    = 64'sd652032874;
	localparam longint ATAN_TBL [0:27] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008
	};

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [30:0] hd;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] tr;
	} pose_t;

	// register copy
	logic [31:0] mpc, itw;
	logic [15:0] lat_gain, fwd_gain, turn_gain;
	logic [9:0]  rate;
	// integrator copy
	logic [15:0] prev_side, prev_left, prev_right;
	logic        primed;
	logic [31:0] wx, wy, yaw_q28;

	pose_t expected_pose[$];
	int    errs, seen;

	assign mismatches    = errs;
	assign pending       = expected_pose.size();
	assign poses_checked = seen;

	function automatic longint rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// exact rnd(a*b, s) without a 96-bit product
	function automatic longint mul_rnd(longint a, logic [31:0] b, int s);
		longint hi, lo, t;
		hi = a * $signed({48'd0, b[31:16]});
		lo = a * $signed({48'd0, b[15:0]});
		t = hi + (64'sd1 <<< (s - 17)) + (lo >>> 16);
		return t >>> (s - 16);
	endfunction

	function automatic void advance_pose(input logic [15:0] sc, lc, rc,
		output logic produced, output pose_t p);
		logic signed [15:0] dsv, dlv, drv;
		logic [15:0] rn;
		longint ds, dl, dr, ms, ml, mr, lat, fwd, tq, dth, yaw, z, x, y, xs, ys, c, sn, h;
		logic [63:0] dx64, dy64, rate64, tr64;
		int quad;
		rn = 16'd0 - rc;
		produced = 1'b0;
		p = '0;
		if (!primed) begin
			prev_side = sc; prev_left = lc; prev_right = rn; primed = 1'b1;
			return;
		end
		dsv = sc - prev_side; dlv = lc - prev_left; drv = rn - prev_right;
		ds = dsv; dl = dlv; dr = drv;
		prev_side = sc; prev_left = lc; prev_right = rn;

		ms = rnd(ds * $signed({32'd0, mpc}), 8);
		ml = rnd(dl * $signed({32'd0, mpc}), 8);
		mr = rnd(dr * $signed({32'd0, mpc}), 8);
		lat = rnd(ms * $signed({48'd0, lat_gain}), 22);
		fwd = rnd((ml + mr) * $signed({48'd0, fwd_gain}), 23);
		tq  = rnd((mr - ml) * $signed({48'd0, turn_gain}), 14);
		dth = mul_rnd(tq, itw, 20);

		// fold the old heading into +-pi/2, then rotate
		yaw = $signed(yaw_q28);
		z = yaw * 4;
		quad = 0;
		if (z > HALF_PI_Q30_L) begin
			z -= HALF_PI_Q30_L; quad = 1;
		end else if (z < -HALF_PI_Q30_L) begin
			z += HALF_PI_Q30_L; quad = -1;
		end
		x = GAIN_K_Q30;
		y = 0;
		for (int k = 0; k < CORDIC_STEPS && k < 28; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_TBL[k];
			end else begin
				x += ys; y -= xs; z += ATAN_TBL[k];
			end
		end
		if (quad == 1) begin
			c = -y; sn = x;
		end else if (quad == -1) begin
			c = y; sn = -x;
		end else begin
			c = x; sn = y;
		end

		// modulo 2^64 products, as the block wraps
		dx64 = (64'(lat) * 64'(c) - 64'(fwd) * 64'(sn) + (64'd1 << 29)) >> 30;
		dy64 = (64'(lat) * 64'(sn) + 64'(fwd) * 64'(c) + (64'd1 << 29)) >> 30;
		wx = wx + dx64[31:0];
		wy = wy + dy64[31:0];

		h = (yaw + dth) % TWO_PI_Q28_L;
		if (h < 0) h += TWO_PI_Q28_L;
		if (h > PI_Q28_L) h -= TWO_PI_Q28_L;
		yaw_q28 = h[31:0];

		rate64 = {54'd0, rate};
		tr64 = (64'(dth) * rate64 + (64'd1 << 11)) >> 12;
		p.px = wx;
		p.py = wy;
		p.hd = h[30:0];
		p.vx = dx64[31:0] * rate;
		p.vy = dy64[31:0] * rate;
		p.tr = tr64[31:0];
		produced = 1'b1;
	endfunction

	task automatic report(input string field, input logic [31:0] want, got);
		$display("%0t pose %0d: %s expected %h got %h", $time, seen, field, want, got);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_t p, e;
		logic made;
		if (!arst_n) begin
			mpc <= 32'd658831; itw <= 32'd43577184;
			lat_gain <= 16'd16384; fwd_gain <= 16'd16384; turn_gain <= 16'd16384;
			rate <= 10'd50;
			prev_side <= '0; prev_left <= '0; prev_right <= '0; primed <= 1'b0;
			wx <= '0; wy <= '0; yaw_q28 <= '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_t'(paddr[4:2]))
					REG_MPC:   mpc = pwdata;
					REG_ITW:   itw = pwdata;
					REG_LATG:  lat_gain = pwdata[15:0];
					REG_FWDG:  fwd_gain = pwdata[15:0];
					REG_TURNG: turn_gain = pwdata[15:0];
					REG_RATE:  rate = pwdata[9:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pose.size() == 0) begin
					report("pose with no request waiting", 32'd0, m_axis_tdata[31:0]);
				end else begin
					e = expected_pose.pop_front();
					if (m_axis_tdata[31:0] !== e.px) report("pos_x", e.px, m_axis_tdata[31:0]);
					if (m_axis_tdata[63:32] !== e.py) report("pos_y", e.py, m_axis_tdata[63:32]);
					if (m_axis_tdata[94:64] !== e.hd)
						report("heading", {1'b0, e.hd}, {1'b0, m_axis_tdata[94:64]});
					if (m_axis_tdata[126:95] !== e.vx) report("vel_x", e.vx, m_axis_tdata[126:95]);
					if (m_axis_tdata[158:127] !== e.vy)
						report("vel_y", e.vy, m_axis_tdata[158:127]);
					if (m_axis_tdata[190:159] !== e.tr)
						report("turn_rate", e.tr, m_axis_tdata[190:159]);
					if (m_axis_tdata[191] !== 1'b0) report("pad", 32'd0, {31'd0, m_axis_tdata[191]});
				end
				seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_pose(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32], made, p);
				if (made) expected_pose.push_back(p);
			end
		end
	end

endmodule

### tb/tb_three_wheel_odometry_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry integrator testbench
// Directed and random encoder samples over several register settings, with
// random stalls on both streams; poses are checked by odo_pose_checker.
// ----------------------------------------------------------------------------
module tb_three_wheel_odometry_integrator;
	import owi_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE = 700;
	localparam logic [4:0] ADDR_SPARE_A = 5'd24;
	localparam logic [4:0] ADDR_SPARE_B = 5'd28;

	logic         clk, arst_n;
	logic [47:0]  s_axis_tdata;
	logic         s_axis_tvalid, s_axis_tready;
	logic [191:0] m_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready;
	logic         psel, penable, pwrite, pready;
	logic [4:0]   paddr;
	logic [31:0]  pwdata, prdata;

	int  mismatches, pending, poses_checked, samples_sent;
	bit  calm, rx_long;
	logic [15:0] cur_s, cur_l, cur_r;

	three_wheel_odometry_integrator dut (.*);

	odo_pose_checker chk (
		.clk, .arst_n, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
		.m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.mismatches, .pending, .poses_checked
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_long) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				rx_long = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic [15:0] sc, lc, rc);
		s_axis_tdata <= {rc, lc, sc};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		cur_s = sc; cur_l = lc; cur_r = rc;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, let every pose arrive, then let the block settle
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic configure(input logic [31:0] mpc, itw, lg, fg, tg, rate);
		reg_write({REG_MPC, 2'b00}, mpc);
		reg_write({REG_ITW, 2'b00}, itw);
		reg_write({REG_LATG, 2'b00}, lg);
		reg_write({REG_FWDG, 2'b00}, fg);
		reg_write({REG_TURNG, 2'b00}, tg);
		reg_write({REG_RATE, 2'b00}, rate);
		reg_write($urandom_range(0, 1) ? ADDR_SPARE_A : ADDR_SPARE_B, $urandom);
	endtask

	// mostly smooth encoder motion; some jumps across the whole range
	task automatic random_sample(input int span);
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 8)
			send_sample(cur_s + 16'($urandom_range(0, 2 * span) - span),
				cur_l + 16'($urandom_range(0, 2 * span) - span),
				cur_r + 16'($urandom_range(0, 2 * span) - span));
		else if (kind == 8)
			send_sample(16'($urandom), 16'($urandom), 16'($urandom));
		else
			send_sample(cur_s ^ 16'h8000, cur_l + 16'h7FFF, 16'h8000);
	endtask

	initial begin
		s_axis_tdata = '0; s_axis_tvalid = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		calm = 1'b0; rx_long = 1'b0; samples_sent = 0;
		cur_s = '0; cur_l = '0; cur_r = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults: priming, still, straight, turning, counter wrap
		send_sample(16'd10, 16'd20, 16'd30);
		send_sample(16'd10, 16'd20, 16'd30);
		send_sample(16'd10, 16'd520, -16'd470);
		send_sample(16'd300, 16'd620, -16'd470);
		send_sample(16'd300, 16'd2620, -16'd270);
		send_sample(16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h7FFF);
		send_sample(16'h0000, 16'hFFFF, 16'h0001);
		send_sample(16'hFFFF, 16'h0000, 16'h8000);
		for (int i = 0; i < 4; i++) send_sample(cur_s, cur_l + 16'd9000, cur_r + 16'd9000);
		drain();

		// everything at its top: large turns wrap the heading
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(16'h7FFF, 16'h8000, 16'h8000);
		send_sample(16'h0000, 16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h0000, 16'h8001);
		send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
		send_sample(16'h1234, 16'h4321, 16'hC000);
		drain();

		// everything zero, velocities read zero
		configure(0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 4; i++) random_sample(30000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 2 == 0)
				configure(32'd600000 + $urandom_range(0, 120000), 32'd40000000 +
					$urandom_range(0, 8000000), $urandom_range(12000, 20000),
					$urandom_range(12000, 20000), $urandom_range(12000, 20000),
					$urandom_range(1, 1000));
			else
				configure($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(1, 1000));
			if (ph == 2) rx_long = 1'b1;
			if (ph == 7) calm = 1'b1;
			for (int i = 0; i < 120; i++) random_sample(ph % 2 == 0 ? 400 : 20000);
			drain();
		end

		$display("%0d encoder samples sent, %0d poses compared over 11 register settings",
			samples_sent, poses_checked);
		$display("settings covered zero and full-scale registers, heading wrap, counter wrap");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
